@@ sv/hslrgb_pkg.sv @@
package hslrgb_pkg;

    // Q1.15 levels for saturation and lightness
    localparam int unsigned Q15_W    = 16;
    localparam logic [15:0] ONE_Q15  = 16'd32768;
    localparam logic [15:0] HALF_Q15 = 16'd16384;

    // Hue rescaled to 3 * 65536 units per turn so thirds and sixths are exact
    localparam int unsigned POS_W          = 18;
    localparam logic [17:0] TURN_U         = 18'd196608;
    localparam logic [17:0] THIRD_U        = 18'd65536;
    localparam logic [17:0] SIXTH_U        = 18'd32768;
    localparam logic [17:0] HALFTURN_U     = 18'd98304;
    localparam logic [17:0] TWOTHIRD_U     = 18'd131072;

    // Helper levels are Q30, channel values Q45
    localparam int unsigned LVL_W = 31;
    localparam int unsigned MUL_W = 16;
    localparam int unsigned VAL_W = 46;
    localparam int unsigned CH_W  = 8;

    localparam logic [MUL_W-1:0] MUL_FULL = 16'd32768;
    localparam logic [CH_W:0]    CH_MAX   = 9'd255;

    // Advance strobes for the per-channel back end of the pipeline
    typedef struct packed {
        logic mul;
        logic sum;
        logic out;
    } hslrgb_adv_t;

endpackage

@@ sv/hsl_to_rgb_converter.sv @@
// HSL to RGB converter. Each input item carries a hue (16-bit fraction of a
// turn, wrapping), a saturation and a lightness (Q1.15, 32768 = 1.0, larger
// codes are clamped to 1.0); each output item carries 8-bit red, green and
// blue, every channel floor(value * 255). Zero lightness yields black and
// zero saturation a grey at the lightness level. The block is a six-stage
// pipeline: clamp and hue offsets, the l*s product, the two helper levels,
// one 31x16 multiply per channel, the Q45 channel sum, and the scale to a
// byte. It takes one item every clock while the output side is not stalled;
// each result is offered on the output from the last stage. Every stage
// carries its own valid bit and advances when it is empty or the stage
// after it moves, so bubbles close up under backpressure and the input
// stays ready until every stage holds an item.
module hsl_to_rgb_converter
    import hslrgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // hue[15:0], saturation[31:16], lightness[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    localparam int unsigned NSTG = 6;

    logic [NSTG:1] vld_reg;
    logic [NSTG:1] vld_next;
    logic [NSTG:1] en;

    // stage 1: clamped levels and hue positions
    logic [Q15_W-1:0] s1_reg, s1_next, l1_reg, l1_next;
    logic [POS_W-1:0] pr1_reg, pr1_next, pg1_reg, pg1_next, pb1_reg, pb1_next;
    // stage 2: l*s and channel weights
    logic [Q15_W-1:0] s2_reg, l2_reg;
    logic [LVL_W-1:0] ls2_reg, ls2_next;
    logic [MUL_W-1:0] mr2_reg, mr2_next, mg2_reg, mg2_next, mb2_reg, mb2_next;
    // stage 3: helper levels
    logic [LVL_W-1:0] lo3_reg, lo3_next, diff3_reg, diff3_next;
    logic [MUL_W-1:0] mr3_reg, mg3_reg, mb3_reg;

    logic [Q15_W-1:0] hue_in, sat_in, lit_in;
    logic [POS_W-1:0] hu;
    logic [Q15_W:0]   lsum;
    logic [31:0]      hi_w, lo_w, diff_w;
    logic [31:0]      ls_w;
    hslrgb_adv_t      adv;
    logic [CH_W-1:0]  red, green, blue;

    // Map a hue position to the weight applied to (hi - lo): rising edge,
    // flat top, falling edge, flat bottom.
    function automatic logic [MUL_W-1:0] weight(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] fall;
        fall = TWOTHIRD_U - pos;
        priority if (pos < SIXTH_U)
            return pos[MUL_W-1:0];
        else if (pos < HALFTURN_U)
            return MUL_FULL;
        else if (pos < TWOTHIRD_U)
            return fall[MUL_W-1:0];
        else
            return '0;
    endfunction

    assign hue_in = s_tdata[15:0];
    assign sat_in = s_tdata[31:16];
    assign lit_in = s_tdata[47:32];

    // Handshake: a stage moves when it is empty or its successor moves.
    always_comb
    begin
        en[NSTG] = !vld_reg[NSTG] || m_tready;
        for (int k = NSTG - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next = vld_reg;
        if (en[1])
        begin
            vld_next[1] = s_tvalid;
        end
        for (int k = 2; k <= NSTG; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = vld_reg[NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Datapath next values
    always_comb
    begin
        // clamp to 1.0 and place the three channels a third of a turn apart
        s1_next  = (sat_in > ONE_Q15) ? ONE_Q15 : sat_in;
        l1_next  = (lit_in > ONE_Q15) ? ONE_Q15 : lit_in;
        hu       = POS_W'({hue_in, 1'b0}) + POS_W'(hue_in);
        pg1_next = hu;
        pr1_next = (hu < TWOTHIRD_U) ? hu + THIRD_U : hu - TWOTHIRD_U;
        pb1_next = (hu >= THIRD_U) ? hu - THIRD_U : hu + (TURN_U - THIRD_U);

        ls_w     = 32'(l1_reg) * 32'(s1_reg);
        ls2_next = ls_w[LVL_W-1:0];
        mr2_next = weight(pr1_reg);
        mg2_next = weight(pg1_reg);
        mb2_next = weight(pb1_reg);

        // hi = l*(1+s) below half lightness, l + s - l*s above; lo = 2l - hi
        lsum = (Q15_W+1)'(l2_reg) + (Q15_W+1)'(s2_reg);
        if (l2_reg < HALF_Q15)
            hi_w = 32'({l2_reg, 15'b0}) + 32'(ls2_reg);
        else
            hi_w = {lsum, 15'b0} - 32'(ls2_reg);
        lo_w       = {l2_reg, 16'b0} - hi_w;
        diff_w     = hi_w - lo_w;
        lo3_next   = lo_w[LVL_W-1:0];
        diff3_next = diff_w[LVL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_reg  <= s1_next;
            l1_reg  <= l1_next;
            pr1_reg <= pr1_next;
            pg1_reg <= pg1_next;
            pb1_reg <= pb1_next;
        end
        if (en[2])
        begin
            s2_reg  <= s1_reg;
            l2_reg  <= l1_reg;
            ls2_reg <= ls2_next;
            mr2_reg <= mr2_next;
            mg2_reg <= mg2_next;
            mb2_reg <= mb2_next;
        end
        if (en[3])
        begin
            lo3_reg   <= lo3_next;
            diff3_reg <= diff3_next;
            mr3_reg   <= mr2_reg;
            mg3_reg   <= mg2_reg;
            mb3_reg   <= mb2_reg;
        end
    end

    // Stages 4 to 6 live in the channel units.
    assign adv.mul = en[4];
    assign adv.sum = en[5];
    assign adv.out = en[6];

    hslrgb_channel u_red
    (
        .clk   (clk),
        .adv   (adv),
        .lo    (lo3_reg),
        .diff  (diff3_reg),
        .mul   (mr3_reg),
        .value (red)
    );

    hslrgb_channel u_green
    (
        .clk   (clk),
        .adv   (adv),
        .lo    (lo3_reg),
        .diff  (diff3_reg),
        .mul   (mg3_reg),
        .value (green)
    );

    hslrgb_channel u_blue
    (
        .clk   (clk),
        .adv   (adv),
        .lo    (lo3_reg),
        .diff  (diff3_reg),
        .mul   (mb3_reg),
        .value (blue)
    );

    assign m_tdata = {blue, green, red};

endmodule

@@ sv/hslrgb_channel.sv @@
module hslrgb_channel
    import hslrgb_pkg::*;
(
    input  logic               clk,
    input  hslrgb_adv_t        adv,
    input  logic [LVL_W-1:0]   lo,
    input  logic [LVL_W-1:0]   diff,
    input  logic [MUL_W-1:0]   mul,
    output logic [CH_W-1:0]    value
);

    logic [LVL_W-1:0]   lo_reg;
    logic [VAL_W-1:0]   prod_reg;
    logic [VAL_W-1:0]   prod_next;
    logic [VAL_W-1:0]   sum_reg;
    logic [VAL_W-1:0]   sum_next;
    logic [CH_W-1:0]    value_reg;
    logic [CH_W-1:0]    value_next;
    logic [VAL_W+7:0]   scaled;
    logic [CH_W:0]      byte_raw;

    always_comb
    begin
        // level difference times the hue weight, at most 2^45
        prod_next  = VAL_W'(diff) * VAL_W'(mul);
        sum_next   = VAL_W'({lo_reg, 15'b0}) + prod_reg;
        // v * 255 as (v << 8) - v, then keep the integer part
        scaled     = {sum_reg, 8'b0} - (VAL_W+8)'(sum_reg);
        byte_raw   = scaled[VAL_W+7:VAL_W-1];
        value_next = (byte_raw > CH_MAX) ? CH_MAX[CH_W-1:0] : byte_raw[CH_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv.mul)
        begin
            lo_reg   <= lo;
            prod_reg <= prod_next;
        end
        if (adv.sum)
        begin
            sum_reg <= sum_next;
        end
        if (adv.out)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule
